// ===== hw/rtl/hbp_pkg.sv =====
package hbp_pkg;

	// PWM resolution: counter period in ticks
	localparam int unsigned LEVELS = 16;
	localparam int unsigned CNT_W  = $clog2(LEVELS);
	localparam int unsigned LVL_W  = $clog2(LEVELS + 1);
	localparam int unsigned NCH    = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LEVELS - 1);

	typedef enum logic {
		REQ_TICK  = 1'b0,
		REQ_WRITE = 1'b1
	} req_type_t;

	// one accepted request
	typedef struct packed {
		req_type_t  req_type;
		logic [1:0] pin_select;
		logic [4:0] duty_level;
	} hbp_item_t;

endpackage

// ===== hw/rtl/hbp_in_stage.sv =====
module hbp_in_stage
	import hbp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  hbp_item_t s_item,
	input  logic      advance,
	output logic      valid_s1,
	output hbp_item_t item_s1
);

	logic valid_s1_q;

	assign s_tready = !valid_s1_q || advance;
	assign valid_s1 = valid_s1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (s_tready) begin
			valid_s1_q <= s_tvalid;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= s_item;
		end
	end

endmodule

// ===== hw/rtl/hbp_engine.sv =====
module hbp_engine
	import hbp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       advance,
	input  hbp_item_t  item_s1,
	output logic [3:0] pins
);

	logic             phase_correct_q;
	logic [CNT_W-1:0] tick_count_q;
	logic [LVL_W-1:0] rise_point_q  [NCH];
	logic [CNT_W-1:0] fall_point_q  [NCH];
	logic [LVL_W-1:0] rise_shadow_q [NCH];
	logic [CNT_W-1:0] fall_shadow_q [NCH];
	logic             update_pending_q;
	logic [NCH-1:0]   direction_q;
	logic [3:0]       pin_levels_q;

	// write decode
	logic [LVL_W-1:0] lvl_sat;
	logic [LVL_W-1:0] rise_new;
	logic [CNT_W-1:0] fall_new;
	logic             wr_ch;

	// tick evaluation
	logic             load_shadow;
	logic [CNT_W-1:0] cnt_next;
	logic [LVL_W-1:0] rise_eff [NCH];
	logic [CNT_W-1:0] fall_eff [NCH];
	logic [3:0]       pins_tick;

	assign pins = pin_levels_q;
	assign wr_ch = item_s1.pin_select[1];

	always_comb begin
		if (32'(item_s1.duty_level) > 32'(LEVELS)) begin
			lvl_sat = LVL_W'(LEVELS);
		end else begin
			lvl_sat = LVL_W'(item_s1.duty_level);
		end
		rise_new = LVL_W'(LEVELS) - lvl_sat;
		// (2L - rise - 1) mod L equals level - 1, wrapping to L-1 at level 0 or L
		if (lvl_sat == '0 || lvl_sat == LVL_W'(LEVELS)) begin
			fall_new = CNT_MAX;
		end else begin
			fall_new = CNT_W'(lvl_sat - LVL_W'(1));
		end
	end

	always_comb begin
		load_shadow = phase_correct_q && (tick_count_q == '0) && update_pending_q;
		cnt_next    = (tick_count_q == CNT_MAX) ? '0 : tick_count_q + CNT_W'(1);
		pins_tick   = pin_levels_q;
		for (int ch = 0; ch < NCH; ch++) begin
			rise_eff[ch] = load_shadow ? rise_shadow_q[ch] : rise_point_q[ch];
			fall_eff[ch] = load_shadow ? fall_shadow_q[ch] : fall_point_q[ch];
			if (phase_correct_q) begin
				if (tick_count_q == fall_eff[ch] && rise_eff[ch] != '0) begin
					pins_tick[2*ch +: 2] = 2'b00;
				end
				if (LVL_W'(cnt_next) == rise_eff[ch] && LVL_W'(fall_eff[ch]) > rise_eff[ch]) begin
					pins_tick[2*ch + (direction_q[ch] ? 0 : 1)] = 1'b1;
				end
			end else begin
				if (tick_count_q == CNT_MAX && rise_eff[ch] != '0) begin
					pins_tick[2*ch +: 2] = 2'b00;
				end
				if (LVL_W'(cnt_next) == rise_eff[ch]) begin
					pins_tick[2*ch + (direction_q[ch] ? 0 : 1)] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_correct_q  <= 1'b1;
			tick_count_q     <= CNT_MAX;
			update_pending_q <= 1'b0;
			direction_q      <= '0;
			pin_levels_q     <= '0;
			for (int ch = 0; ch < NCH; ch++) begin
				rise_point_q[ch]  <= '0;
				fall_point_q[ch]  <= '0;
				rise_shadow_q[ch] <= '0;
				fall_shadow_q[ch] <= '0;
			end
		end else begin
			if (cfg_we) begin
				phase_correct_q <= cfg_wdata;
			end
			if (advance) begin
				unique case (item_s1.req_type)
					REQ_TICK: begin
						tick_count_q <= cnt_next;
						pin_levels_q <= pins_tick;
						if (load_shadow) begin
							update_pending_q <= 1'b0;
							for (int ch = 0; ch < NCH; ch++) begin
								rise_point_q[ch] <= rise_shadow_q[ch];
								fall_point_q[ch] <= fall_shadow_q[ch];
							end
						end
					end
					REQ_WRITE: begin
						for (int ch = 0; ch < NCH; ch++) begin
							if (wr_ch == ch[0]) begin
								direction_q[ch] <= ~item_s1.pin_select[0];
								if (phase_correct_q) begin
									rise_shadow_q[ch] <= rise_new;
									fall_shadow_q[ch] <= fall_new;
								end else begin
									rise_point_q[ch] <= rise_new;
								end
							end
						end
						if (phase_correct_q) begin
							update_pending_q <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// ===== hw/rtl/dual_hbridge_pwm_generator_core.sv =====
// Two-channel PWM (phase-correct or plain) for H-bridge pin pairs.
//
// Input stream (s_*): tuser = request kind (0 tick, 1 duty write);
//   tdata = pin select [1:0], duty level [6:2], bit 7 zero.
// Output stream (m_*): one item per input item, tdata = four pin levels
//   (ch1 A, ch1 B, ch2 A, ch2 B from bit 0 up), upper bits zero. A duty write
//   returns the unchanged pin levels; a tick returns the levels after it.
// Config: cfg_we/cfg_wdata write phase_correct (reset 1); only while idle.
//
// Items pass through the input register, then the PWM state update whose
// pin register is itself the result register. One item per cycle is taken
// while m_tready stays high; the single state update stage sets that rate.
// When m_tready is low the result holds, one more item waits in the input
// register, and s_tready drops only once both are full.
// Reset (arst_n, async, active low) clears both valid flags, sets the tick
// counter to LEVELS-1, pins low, points, shadows and directions to zero,
// and selects phase-correct mode.
module dual_hbridge_pwm_generator_core
	import hbp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [1:0] pin_select, [6:2] duty_level, [7] zero
	input  logic       s_tuser,   // [0] req_type
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [0] ch1_pin_a, [1] ch1_pin_b, [2] ch2_pin_a,
	                              // [3] ch2_pin_b, [7:4] zero
	input  logic       cfg_we,
	input  logic       cfg_wdata
);

	hbp_item_t  s_item;
	hbp_item_t  item_s1;
	logic       valid_s1;
	logic       advance;
	logic       m_tvalid_q;
	logic [3:0] pins;

	assign s_item.req_type   = req_type_t'(s_tuser);
	assign s_item.pin_select = s_tdata[1:0];
	assign s_item.duty_level = s_tdata[6:2];

	// state moves forward when the result slot is free or being emptied
	assign advance = valid_s1 && (!m_tvalid_q || m_tready);

	hbp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_item   (s_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	hbp_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.advance   (advance),
		.item_s1   (item_s1),
		.pins      (pins)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, pins};

	// back-pressure only when both stages are occupied and stalled
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_tvalid_q && !m_tready))
		else $error("s_tready low with a free stage");

	// every state update produces a visible result
	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("result lost after update");

	// pin levels change only on an update
	a_pins_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(m_tdata))
		else $error("pins changed without an item");

endmodule

// ===== dv/dual_hbridge_pwm_generator_core_tb.sv =====
module dual_hbridge_pwm_generator_core_tb;
	import hbp_pkg::*;

	// cycles with no item moving on either side before the run is abandoned
	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned PHASE_ITEMS  = 200;
	localparam int unsigned PHASE_COUNT  = 6;
	localparam int unsigned DRAIN_CYCLES = 6;

	// Predictor of the four drive pins plus the queue of pin levels still owed
	// by the block. Keeps its own copy of counter, points, shadows and mode.
	class hbridge_pin_model;
		bit               phase_correct;
		logic [CNT_W-1:0] tick_count;
		logic [LVL_W-1:0] rise_pt [NCH];
		logic [LVL_W-1:0] rise_sh [NCH];
		logic [CNT_W-1:0] fall_pt [NCH];
		logic [CNT_W-1:0] fall_sh [NCH];
		bit               load_pending;
		bit               drive_a [NCH];
		logic [3:0]       pins;
		logic [3:0]       expected_pins [$];
		int               mismatch_count;

		function new();
			phase_correct = 1'b1;
			tick_count    = CNT_MAX;
			for (int ch = 0; ch < NCH; ch++) begin
				rise_pt[ch] = '0;
				rise_sh[ch] = '0;
				fall_pt[ch] = '0;
				fall_sh[ch] = '0;
				drive_a[ch] = 1'b0;
			end
			load_pending   = 1'b0;
			pins           = '0;
			mismatch_count = 0;
		endfunction

		function void raise_pin(int ch);
			pins[2*ch + (drive_a[ch] ? 0 : 1)] = 1'b1;
		endfunction

		function void pwm_tick();
			if (phase_correct) begin
				// shadows land only when the counter sits at zero
				if (tick_count == 0 && load_pending) begin
					for (int ch = 0; ch < NCH; ch++) begin
						rise_pt[ch] = rise_sh[ch];
						fall_pt[ch] = fall_sh[ch];
					end
					load_pending = 1'b0;
				end
				// full on (rise 0) never falls
				for (int ch = 0; ch < NCH; ch++)
					if (tick_count == fall_pt[ch] && rise_pt[ch] != 0)
						pins[2*ch +: 2] = 2'b00;
				tick_count = (tick_count == CNT_MAX) ? '0 : tick_count + 1'b1;
				for (int ch = 0; ch < NCH; ch++)
					if (tick_count == rise_pt[ch] && fall_pt[ch] > rise_pt[ch])
						raise_pin(ch);
			end else begin
				if (tick_count == CNT_MAX)
					for (int ch = 0; ch < NCH; ch++)
						if (rise_pt[ch] != 0)
							pins[2*ch +: 2] = 2'b00;
				tick_count = (tick_count == CNT_MAX) ? '0 : tick_count + 1'b1;
				for (int ch = 0; ch < NCH; ch++)
					if (tick_count == rise_pt[ch])
						raise_pin(ch);
			end
		endfunction

		function void duty_write(logic [1:0] sel, logic [4:0] level);
			int ch;
			int lv;
			int rise;
			ch   = sel[1];
			lv   = (level > LEVELS) ? LEVELS : level;
			rise = LEVELS - lv;
			// pin A selected means forward drive
			drive_a[ch] = ~sel[0];
			if (phase_correct) begin
				rise_sh[ch]  = LVL_W'(rise);
				fall_sh[ch]  = CNT_W'((2*LEVELS - rise - 1) % LEVELS);
				load_pending = 1'b1;
			end else begin
				rise_pt[ch] = LVL_W'(rise);
			end
		endfunction

		function void note_item(hbp_item_t item);
			if (item.req_type == REQ_WRITE)
				duty_write(item.pin_select, item.duty_level);
			else
				pwm_tick();
			expected_pins.push_back(pins);
		endfunction

		function void note_mismatch(string msg);
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("MISMATCH at %0t: %s", $time, msg);
		endfunction

		function void check_pins(logic [7:0] data);
			logic [3:0] want;
			string      pin_name [4];
			pin_name = '{"ch1_pin_a", "ch1_pin_b", "ch2_pin_a", "ch2_pin_b"};
			if (expected_pins.size() == 0) begin
				note_mismatch($sformatf("result 0x%02h with nothing pending", data));
				return;
			end
			want = expected_pins.pop_front();
			for (int i = 0; i < 4; i++)
				if (data[i] !== want[i])
					note_mismatch($sformatf("%s expected %0b actual %0b",
						pin_name[i], want[i], data[i]));
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = '0;    // [1:0] pin_select, [6:2] duty_level, [7] zero
	logic       s_tuser = 1'b0;  // [0] req_type
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;         // [0] ch1_pin_a, [1] ch1_pin_b, [2] ch2_pin_a,
	                             // [3] ch2_pin_b, [7:4] zero
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;

	hbridge_pin_model model = new();
	bit               steady = 1'b0;   // no gaps and no stalls while set
	int unsigned      quiet_cycles = 0;

	dual_hbridge_pwm_generator_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: check each accepted item, then pick the next ready level.
	// Reads at the edge see pre-edge values, since the block updates by NBA.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			model.check_pins(m_tdata);
		m_tready <= steady || ($urandom_range(99) >= 20);
	end

	// Watchdog: any item moving on either side restarts the count
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic hbp_item_t pwm_item(req_type_t rq, logic [1:0] sel, logic [4:0] lvl);
		hbp_item_t item;
		item.req_type   = rq;
		item.pin_select = sel;
		item.duty_level = lvl;
		return item;
	endfunction

	// Mostly ticks so the counter runs through whole periods; the odd write
	// moves a point or flips a direction. A quarter of levels use all 5 bits.
	function automatic hbp_item_t random_item();
		logic [4:0] lvl;
		if ($urandom_range(99) < 25)
			lvl = 5'($urandom_range(31));
		else
			lvl = 5'($urandom_range(LEVELS));
		if ($urandom_range(99) < 12)
			return pwm_item(REQ_WRITE, 2'($urandom_range(3)), lvl);
		return pwm_item(REQ_TICK, 2'($urandom_range(3)), lvl);
	endfunction

	// Holds valid until the block takes the item; the prediction is made at
	// the accepting edge.
	task automatic send_item(hbp_item_t item);
		while (!steady && $urandom_range(99) < 20) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, item.duty_level, item.pin_select};
		s_tuser  <= item.req_type;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		model.note_item(item);
	endtask

	// Mode changes only with the pipe empty; every item returns a result,
	// so an empty queue plus the pipe depth means idle.
	task automatic set_phase_mode(bit pc);
		s_tvalid <= 1'b0;
		while (model.expected_pins.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= pc;
		@(posedge clk);
		cfg_we <= 1'b0;
		model.phase_correct = pc;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_phase_mode(1'b1);

		// directed: counter starts at LEVELS-1, so the first tick brings it to
		// zero and the second tick loads the shadows
		send_item(pwm_item(REQ_WRITE, 2'd0, 5'd8));
		send_item(pwm_item(REQ_WRITE, 2'd2, 5'd31));   // saturates, full on
		repeat (4) send_item(pwm_item(REQ_TICK, 2'd0, 5'd0));
		send_item(pwm_item(REQ_WRITE, 2'd1, 5'd0));    // level zero, never rises
		send_item(pwm_item(REQ_WRITE, 2'd3, 5'd17));   // just over LEVELS
		repeat (8) send_item(pwm_item(REQ_TICK, 2'd3, 5'd31));
		send_item(pwm_item(REQ_WRITE, 2'd0, 5'd16));
		send_item(pwm_item(REQ_WRITE, 2'd2, 5'd1));
		repeat (4) send_item(pwm_item(REQ_TICK, 2'd1, 5'd21));
		send_item(pwm_item(REQ_WRITE, 2'd3, 5'd15));

		// random phases alternate plain and phase-correct mode; a write left
		// pending in phase-correct mode rides through the plain phase after it
		for (int p = 0; p < PHASE_COUNT; p++) begin
			set_phase_mode(p[0]);
			steady = (p == 3);
			repeat (PHASE_ITEMS) send_item(random_item());
		end
		steady = 1'b0;
		s_tvalid <= 1'b0;

		while (model.expected_pins.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (model.mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/hbp_pkg.sv
hw/rtl/hbp_in_stage.sv
hw/rtl/hbp_engine.sv
hw/rtl/dual_hbridge_pwm_generator_core.sv
dv/dual_hbridge_pwm_generator_core_tb.sv
